### rtl/dmf_pkg.sv
`timescale 1ns / 1ps

package dmf_pkg;

    localparam int unsigned ADDR_W    = 16;
    localparam int unsigned ID_W      = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned PADDR_W   = 4;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [TIME_W-1:0] WINDOW_RESET    = 32'd6000;
    localparam logic [ADDR_W-1:0] FOLD_LOW_RESET  = 16'h0001;
    localparam logic [ADDR_W-1:0] FOLD_HIGH_RESET = 16'h0010;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_WINDOW    = 2'd0,
        REG_FOLD_LOW  = 2'd1,
        REG_FOLD_HIGH = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### rtl/duplicate_message_filter.sv
`timescale 1ns / 1ps

// Replay filter for received messages. Each word on the input channel is
// one message (source address, transaction id, current time in ms); each
// word on the output channel is its status: 0 when the message was new and
// has been recorded, 1 when a matching entry is still inside window_ms.
// The recent entries live in a single-port memory of ENTRIES words that is
// walked one entry per cycle; a new item is accepted only once the walk for
// the previous one is over and its result is in the output register. The
// result sits in that register, so the next item is taken while that result
// waits. Entries never written since reset read as zeros through per-entry
// valid bits; there is no clearing pass. Registers: window_ms at 0x0,
// fold_low at 0x4, fold_high at 0x8; write them only while the block is
// idle.
module duplicate_message_filter
    import dmf_pkg::*;
#(
    parameter int unsigned ENTRIES = 5
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADDR_W-1:0]   source_address,
    input  logic [ID_W-1:0]     transaction_id,
    input  logic [TIME_W-1:0]   now_ms,

    output logic                out_valid,
    input  logic                out_ready,
    output logic                status
);

    localparam int unsigned PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(ENTRIES - 1);

    // configuration registers
    logic [TIME_W-1:0] window_reg;
    logic [ADDR_W-1:0] fold_low_reg;
    logic [ADDR_W-1:0] fold_high_reg;
    logic              cfg_we;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_we  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            fold_low_reg  <= FOLD_LOW_RESET;
            fold_high_reg <= FOLD_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_WINDOW:    window_reg    <= pwdata[TIME_W-1:0];
                REG_FOLD_LOW:  fold_low_reg  <= pwdata[ADDR_W-1:0];
                REG_FOLD_HIGH: fold_high_reg <= pwdata[ADDR_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WINDOW:    prdata = window_reg;
            REG_FOLD_LOW:  prdata = {{(PDATA_W-ADDR_W){1'b0}}, fold_low_reg};
            REG_FOLD_HIGH: prdata = {{(PDATA_W-ADDR_W){1'b0}}, fold_high_reg};
            default:       prdata = '0;
        endcase
    end

    // control
    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic              rd_pend_reg;
    logic              repeat_reg, repeat_next;
    logic              out_valid_reg, out_valid_next;
    logic              status_reg, status_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    // item under test
    logic [ADDR_W-1:0] addr_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] now_reg;
    logic [ADDR_W-1:0] folded_addr;

    // entry memory
    entry_t            mem [ENTRIES];
    entry_t            mem_q;
    logic              q_valid_reg;
    entry_t            rd_entry;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_idx;
    logic              mem_we;
    entry_t            wr_entry;

    logic              in_fire;
    logic              out_free;
    logic [TIME_W-1:0] expiry_time;
    logic              hit;
    logic              repeat_final;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign folded_addr = (source_address >= fold_low_reg && source_address <= fold_high_reg)
                         ? fold_low_reg : source_address;

    // an entry never written reads as all zeros
    assign rd_entry    = q_valid_reg ? mem_q : '0;
    assign expiry_time = rd_entry.stamp + window_reg;
    assign hit      = rd_pend_reg && (rd_entry.id == id_reg) && (rd_entry.addr == addr_reg)
                      && (now_reg < expiry_time);
    assign repeat_final = repeat_reg || hit;

    assign wr_entry = '{id: id_reg, addr: addr_reg, stamp: now_reg};

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        wr_ptr_next    = wr_ptr_reg;
        repeat_next    = repeat_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        valid_next     = valid_reg;
        rd_en          = 1'b0;
        rd_idx         = scan_idx_reg;
        mem_we         = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    rd_en       = 1'b1;
                    rd_idx      = '0;
                    repeat_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                rd_en       = 1'b1;
                repeat_next = repeat_final;
            end
            S_CHECK:
            begin
                repeat_next = repeat_final;
                // record a new message at the ring pointer
                if (!repeat_final)
                begin
                    mem_we                 = 1'b1;
                    valid_next[wr_ptr_reg] = 1'b1;
                    wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
                end
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = repeat_final;
                    state_next     = S_IDLE;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = repeat_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // advance the walk over the stored entries
        if (rd_en)
        begin
            if (rd_idx == LAST_IDX)
                state_next = S_CHECK;
            else
            begin
                scan_idx_next = rd_idx + 1'b1;
                state_next    = S_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_idx_reg  <= '0;
            wr_ptr_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            repeat_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_pend_reg   <= rd_en;
            repeat_reg    <= repeat_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            addr_reg <= folded_addr;
            id_reg   <= transaction_id;
            now_reg  <= now_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_ptr_reg] <= wr_entry;
        if (rd_en)
        begin
            mem_q       <= mem[rd_idx];
            q_valid_reg <= valid_reg[rd_idx];
        end
    end

    // assertions
    ap_rd_pend_src: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> ($past(state_reg) == S_IDLE || $past(state_reg) == S_SCAN))
        else $error("read data arrived without an issued read");

    ap_ptr_move: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(wr_ptr_reg) |-> ($past(state_reg) == S_CHECK && !$past(repeat_final)))
        else $error("ring pointer moved outside a record");

    ap_check_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> rd_pend_reg)
        else $error("final compare without read data");

    ap_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_CHECK || $past(state_reg) == S_DONE))
        else $error("result issued outside check or done");

    ap_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_SCAN || state_reg == S_CHECK))
        else $error("accepted word did not start a scan");

endmodule

### verif/tb_duplicate_message_filter.sv
`timescale 1ns / 1ps

module tb_duplicate_message_filter;
    import dmf_pkg::*;

    localparam int unsigned NUM_ENTRIES    = 5;
    localparam int unsigned SETTLE_CYCLES  = 4 * (NUM_ENTRIES + 1);
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned NUM_PHASES     = 12;
    localparam int unsigned PHASE_ITEMS    = 157;

    localparam logic ST_NEW    = 1'b0;
    localparam logic ST_REPEAT = 1'b1;

    typedef enum logic {
        ROW_MSG,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        reg_idx_t           idx;
        logic [PDATA_W-1:0] value;
        logic [ADDR_W-1:0]  addr;
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  now;
        logic               typed;
        logic               status;
    } step_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [ADDR_W-1:0]  source_address;
    logic [ID_W-1:0]    transaction_id;
    logic [TIME_W-1:0]  now_ms;
    logic               out_valid;
    logic               out_ready;
    logic               status;

    // predictor state
    logic [ID_W-1:0]    seen_id   [NUM_ENTRIES];
    logic [ADDR_W-1:0]  seen_addr [NUM_ENTRIES];
    logic [TIME_W-1:0]  seen_time [NUM_ENTRIES];
    int unsigned        ring_ptr;
    logic [TIME_W-1:0]  window_cfg;
    logic [ADDR_W-1:0]  fold_lo_cfg;
    logic [ADDR_W-1:0]  fold_hi_cfg;

    logic               status_queue[$];
    int unsigned        mismatches;
    int unsigned        idle_cycles;
    int unsigned        gap_pct;
    int unsigned        stall_pct;
    logic               quiet;

    duplicate_message_filter #(
        .ENTRIES(NUM_ENTRIES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .source_address(source_address),
        .transaction_id(transaction_id),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic filter_message(input logic [ADDR_W-1:0] src,
                                            input logic [ID_W-1:0]   tid,
                                            input logic [TIME_W-1:0] now);
        logic [ADDR_W-1:0] key;
        logic [TIME_W-1:0] expiry;
        logic              hit;
        key = (src >= fold_lo_cfg && src <= fold_hi_cfg) ? fold_lo_cfg : src;
        hit = 1'b0;
        for (int e = 0; e < NUM_ENTRIES; e++)
        begin
            expiry = seen_time[e] + window_cfg;
            if (seen_id[e] == tid && seen_addr[e] == key && now < expiry)
                hit = 1'b1;
        end
        if (hit)
            return ST_REPEAT;
        seen_id[ring_ptr]   = tid;
        seen_addr[ring_ptr] = key;
        seen_time[ring_ptr] = now;
        ring_ptr = (ring_ptr == NUM_ENTRIES - 1) ? 0 : ring_ptr + 1;
        return ST_NEW;
    endfunction

    function automatic step_t msg_row(input logic [ADDR_W-1:0] addr,
                                      input logic [ID_W-1:0]   id,
                                      input logic [TIME_W-1:0] now,
                                      input logic              typed,
                                      input logic              st);
        step_t r;
        r        = '0;
        r.kind   = ROW_MSG;
        r.idx    = REG_NONE;
        r.addr   = addr;
        r.id     = id;
        r.now    = now;
        r.typed  = typed;
        r.status = st;
        return r;
    endfunction

    function automatic step_t cfg_row(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        step_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.value = value;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    // write, then read back, one register
    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] mask;
        mask = (idx == REG_WINDOW) ? '1 : PDATA_W'(16'hFFFF);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_WINDOW:    window_cfg  = value[TIME_W-1:0];
            REG_FOLD_LOW:  fold_lo_cfg = value[ADDR_W-1:0];
            REG_FOLD_HIGH: fold_hi_cfg = value[ADDR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if ((prdata & mask) != (value & mask))
            report_mismatch("register readback", value & mask, prdata & mask);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // hold the word until taken, then predict its status
    task automatic send_message(input logic [ADDR_W-1:0] addr, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] now, input logic typed,
                                input logic st);
        int unsigned gap_n;
        logic        predicted;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            gap_n = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap_n)
                @(negedge clk);
        end
        in_valid       <= 1'b1;
        source_address <= addr;
        transaction_id <= id;
        now_ms         <= now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = filter_message(addr, id, now);
        status_queue.push_back(typed ? st : predicted);
    endtask

    // drop valid, drain all pending status words, let the scan finish
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (status_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (status_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: status word %0d with no message pending", $realtime, status);
            end
            else
            begin
                logic want;
                want = status_queue.pop_front();
                if (status !== want)
                    report_mismatch("status", 32'(want), 32'(status));
            end
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int unsigned hold_n;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && !quiet && $urandom_range(0, 99) < stall_pct)
            begin
                hold_n = $urandom_range(1, 11);
                out_ready <= 1'b0;
                repeat (hold_n - 1)
                    @(negedge clk);
            end
            else
                out_ready <= rst_n;
        end
    end

    initial
    begin
        step_t             script[$];
        step_t             row;
        logic [ADDR_W-1:0] r_addr;
        logic [ID_W-1:0]   r_id;
        logic [TIME_W-1:0] r_now;
        logic [TIME_W-1:0] clock_ms;
        logic [PDATA_W-1:0] w;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        source_address = '0;
        transaction_id = '0;
        now_ms         = '0;
        mismatches     = 0;
        idle_cycles    = 0;
        quiet          = 1'b0;
        gap_pct        = 20;
        stall_pct      = 20;
        ring_ptr       = 0;
        window_cfg     = WINDOW_RESET;
        fold_lo_cfg    = FOLD_LOW_RESET;
        fold_hi_cfg    = FOLD_HIGH_RESET;
        clock_ms       = 0;
        for (int e = 0; e < NUM_ENTRIES; e++)
        begin
            seen_id[e]   = '0;
            seen_addr[e] = '0;
            seen_time[e] = '0;
        end

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // cleared entries match address 0, id 0 until the window runs out
        script.push_back(msg_row(16'h0000, 8'h00, 32'd0, 1'b1, ST_REPEAT));
        script.push_back(msg_row(16'h0000, 8'h00, 32'd6000, 1'b1, ST_NEW));
        // fold range 1..16 maps onto address 1
        script.push_back(msg_row(16'h0005, 8'h07, 32'd100, 1'b0, ST_NEW));
        script.push_back(msg_row(16'h0010, 8'h07, 32'd200, 1'b0, ST_NEW));
        script.push_back(msg_row(16'h0011, 8'h07, 32'd200, 1'b0, ST_NEW));
        script.push_back(msg_row(16'h0001, 8'h07, 32'd6100, 1'b0, ST_NEW));
        // time wrap in both directions
        script.push_back(msg_row(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, ST_NEW));
        script.push_back(msg_row(16'hFFFF, 8'hFF, 32'h0000_0000, 1'b0, ST_NEW));
        script.push_back(msg_row(16'hABCD, 8'h5A, 32'hFFFF_F000, 1'b0, ST_NEW));
        script.push_back(msg_row(16'hABCD, 8'h5A, 32'hFFFF_F100, 1'b0, ST_NEW));
        // zero window
        script.push_back(cfg_row(REG_WINDOW, 32'h0000_0000));
        script.push_back(msg_row(16'h1234, 8'h81, 32'h8000_0000, 1'b0, ST_NEW));
        script.push_back(msg_row(16'h1234, 8'h81, 32'h8000_0000, 1'b0, ST_NEW));
        script.push_back(msg_row(16'h1234, 8'h81, 32'h7FFF_FFFF, 1'b0, ST_NEW));
        // widest window, empty fold range
        script.push_back(cfg_row(REG_WINDOW, 32'hFFFF_FFFF));
        script.push_back(cfg_row(REG_FOLD_LOW, 32'h0000_FFFF));
        script.push_back(cfg_row(REG_FOLD_HIGH, 32'h0000_0000));
        script.push_back(msg_row(16'h0000, 8'h00, 32'h0000_0010, 1'b0, ST_NEW));
        script.push_back(msg_row(16'h0008, 8'h33, 32'h0000_0001, 1'b0, ST_NEW));
        script.push_back(msg_row(16'h0009, 8'h33, 32'h0000_0002, 1'b0, ST_NEW));
        // fold every address onto 0
        script.push_back(cfg_row(REG_FOLD_LOW, 32'h0000_0000));
        script.push_back(cfg_row(REG_FOLD_HIGH, 32'h0000_FFFF));
        script.push_back(msg_row(16'hFFFF, 8'h44, 32'h0000_0003, 1'b0, ST_NEW));
        script.push_back(msg_row(16'h0000, 8'h44, 32'h0000_0004, 1'b0, ST_NEW));
        script.push_back(msg_row(16'h7777, 8'h44, 32'h0000_0005, 1'b0, ST_NEW));
        // single-address fold range
        script.push_back(cfg_row(REG_FOLD_LOW, 32'h0000_8000));
        script.push_back(cfg_row(REG_FOLD_HIGH, 32'h0000_8000));
        script.push_back(msg_row(16'h8000, 8'hC3, 32'h5555_5555, 1'b0, ST_NEW));
        script.push_back(msg_row(16'h8001, 8'hC3, 32'h5555_5556, 1'b0, ST_NEW));
        script.push_back(msg_row(16'h8000, 8'hC3, 32'hAAAA_AAAA, 1'b0, ST_NEW));

        for (int k = 0; k < script.size(); k++)
        begin
            row = script[k];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_reg(row.idx, row.value);
            end
            else
                send_message(row.addr, row.id, row.now, row.typed, row.status);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            case ($urandom_range(0, 7))
                0:       w = 32'h0000_0000;
                1:       w = 32'hFFFF_FFFF;
                2:       w = $urandom;
                default: w = $urandom_range(500, 8000);
            endcase
            case ($urandom_range(0, 3))
                0:
                begin
                    lo = ADDR_W'($urandom);
                    hi = ADDR_W'($urandom);
                end
                1:
                begin
                    lo = ADDR_W'($urandom);
                    hi = lo;
                end
                2:
                begin
                    lo = ADDR_W'($urandom_range(0, 100));
                    hi = ADDR_W'(lo + $urandom_range(0, 40));
                end
                default:
                begin
                    lo = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    hi = ~lo;
                end
            endcase
            write_reg(REG_WINDOW, w);
            write_reg(REG_FOLD_LOW, {16'h0000, lo});
            write_reg(REG_FOLD_HIGH, {16'h0000, hi});
            quiet     = (phase == NUM_PHASES - 1);
            gap_pct   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 40);
            stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 40);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    r_addr = ADDR_W'($urandom);
                    r_id   = ID_W'($urandom);
                    r_now  = $urandom;
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       r_addr = ADDR_W'(fold_lo_cfg + $urandom_range(0, 3));
                        1:       r_addr = 16'h0000;
                        2:       r_addr = ADDR_W'(16'h0100 + $urandom_range(0, 2));
                        default: r_addr = ADDR_W'($urandom);
                    endcase
                    r_id = ID_W'($urandom_range(0, 3));
                    // walk time forward, now and then right up to the wrap
                    if ($urandom_range(0, 49) == 0)
                        clock_ms = 32'hFFFF_F000 + $urandom_range(0, 2048);
                    else
                        clock_ms = clock_ms + $urandom_range(0, 2500);
                    r_now = clock_ms;
                end
                send_message(r_addr, r_id, r_now, 1'b0, ST_NEW);
            end
        end

        settle();
        if (status_queue.size() != 0)
        begin
            mismatches += status_queue.size();
            $display("%0d status words never arrived", status_queue.size());
        end
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
